// ===== src/mep_pkg.sv =====
// shared types and constants for the mandelbrot escape-time pixel block
// used by mep_ctrl, mep_dp and mandelbrot_escape_time_pixel; no dependencies
`default_nettype none

package mep_pkg;

    // fixed-point format of complex values: signed, FRAC_BITS fraction bits in a word
    localparam int FRAC_BITS   = 28;
    localparam int WORD_W      = 32;

    // pixel coordinate and offset widths
    localparam int PIX_W       = 12;
    localparam int SIZE_W      = 13;
    localparam int OFF_W       = SIZE_W + 2;
    localparam int MAG_W       = SIZE_W + 1;
    localparam int PROD_W      = MAG_W + WORD_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int WIDE_W      = 2 * WORD_W;

    // gray level and its divider
    localparam int GRAY_W      = 8;
    localparam int DCNT_W      = 3;
    localparam logic [DCNT_W-1:0] DIV_FIRST = DCNT_W'(GRAY_W - 1);

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_RE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_IM      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_STEP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ITERATION_LIMIT = 3'd5;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_ADD,
        ST_MUL,
        ST_UPD,
        ST_DIV,
        ST_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_pixel;
        logic map_mul;
        logic map_add;
        logic iter_mul;
        logic iter_upd;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic count_done;
        logic escaped;
        logic div_last;
    } status_t;

    // clamp a signed wide value to the signed word range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic pos_over;
        logic neg_over;
        pos_over = !v[WIDE_W-1] && (|v[WIDE_W-2:WORD_W-1]);
        neg_over = v[WIDE_W-1] && !(&v[WIDE_W-2:WORD_W-1]);
        if (pos_over)
        begin
            sat_word = {1'b0, {(WORD_W-1){1'b1}}};
        end
        else if (neg_over)
        begin
            sat_word = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            sat_word = v[WORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/mandelbrot_escape_time_pixel.sv =====
// top level of the mandelbrot escape-time pixel block: config registers and stream ports
// depends on mep_pkg, mep_ctrl and mep_dp
`default_nettype none

// usage
// - input stream s_*: one word per pixel, s_tdata holds pixel_x and pixel_y
// - output stream m_*: one word per pixel, m_tdata holds iterations and gray_level
// - config port: cfg_we writes cfg_data into the register selected by cfg_index
//   (0 center_re, 1 center_im, 2 pixel_step, 3 image_width, 4 image_height,
//   5 iteration_limit); other indexes are ignored; write only while idle
// - each pixel is mapped to c = center + (2*pixel - size) * step / 2, saturated,
//   then z = z*z + c is iterated from zero until |z|^2 > 4 or the limit is hit
// - in each escape iteration the three 32x32 products are registered, then
//   the escape compare and the next z are formed
// - from input accept to output valid a word passes the mapping states ST_MAP
//   and ST_ADD, the iteration loop, the bit-serial gray divider and the output
//   load; an escaping point leaves the loop from ST_UPD, one stopped by the limit from ST_MUL
// - with no stall a new word is taken in the cycle after the result load
// - one pixel is in flight at a time; the next word is taken as soon as the
//   result sits in the output register, so a stall on m_* holds at most one
//   finished word and blocks the next result only at its final load
// - reset clears the controller and output valid and loads the default view:
//   center 0, step 20132659, 640 x 480 image, limit 100
module mandelbrot_escape_time_pixel
    import mep_pkg::*;
#(
    parameter int ITER_BITS = 10
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // input words
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [2*PIX_W-1:0]      s_tdata,   // pixel_x, pixel_y
    // result words
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [((ITER_BITS+GRAY_W+7)/8)*8-1:0] m_tdata,  // iterations, gray_level
    // configuration writes
    input  wire logic                    cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [WORD_W-1:0]       cfg_data
);

    localparam int OUT_W = ((ITER_BITS + GRAY_W + 7) / 8) * 8;

    // configuration registers
    logic signed [WORD_W-1:0] center_re_reg, center_im_reg;
    logic [WORD_W-1:0]        pixel_step_reg;
    logic [SIZE_W-1:0]        image_width_reg, image_height_reg;
    logic [ITER_BITS-1:0]     iteration_limit_reg;

    cmd_t                     cmd;
    status_t                  status;
    logic [ITER_BITS-1:0]     iterations;
    logic [GRAY_W-1:0]        gray_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_re_reg       <= '0;
            center_im_reg       <= '0;
            pixel_step_reg      <= 32'd20132659;
            image_width_reg     <= 13'd640;
            image_height_reg    <= 13'd480;
            iteration_limit_reg <= ITER_BITS'(100);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_RE:       center_re_reg       <= cfg_data;
                REG_CENTER_IM:       center_im_reg       <= cfg_data;
                REG_PIXEL_STEP:      pixel_step_reg      <= cfg_data;
                REG_IMAGE_WIDTH:     image_width_reg     <= cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:    image_height_reg    <= cfg_data[SIZE_W-1:0];
                REG_ITERATION_LIMIT: iteration_limit_reg <= cfg_data[ITER_BITS-1:0];
                default:
                begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    mep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mep_dp #(
        .ITER_BITS (ITER_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .pixel_x         (s_tdata[PIX_W-1:0]),
        .pixel_y         (s_tdata[2*PIX_W-1:PIX_W]),
        .center_re       (center_re_reg),
        .center_im       (center_im_reg),
        .pixel_step      (pixel_step_reg),
        .image_width     (image_width_reg),
        .image_height    (image_height_reg),
        .iteration_limit (iteration_limit_reg),
        .iterations      (iterations),
        .gray_level      (gray_level)
    );

    // result word, zero padded to whole bytes
    assign m_tdata = OUT_W'({gray_level, iterations});

endmodule

`default_nettype wire

// ===== src/mep_ctrl.sv =====
// controller state machine for the mandelbrot escape-time pixel block
// depends on mep_pkg; drives mep_dp through cmd_t and reads status_t
`default_nettype none

module mep_ctrl
    import mep_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_pixel = 1'b1;
                    state_next     = ST_MAP;
                end
            end
            ST_MAP:
            begin
                cmd.map_mul = 1'b1;
                state_next  = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.map_add = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                if (status.count_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    cmd.iter_mul = 1'b1;
                    state_next   = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (status.escaped)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    cmd.iter_upd = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    // an accepted word always starts the coordinate mapping
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_MAP))
        else $error("accepted word did not start mapping");

    // a stalled result word is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten while stalled");

    // an escaped point goes straight to the gray division
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && status.escaped) |=> (state_reg == ST_DIV))
        else $error("escape did not end the iteration");

endmodule

`default_nettype wire

// ===== src/mep_dp.sv =====
// datapath for the mandelbrot escape-time pixel block: mapping, iteration, gray divider
// depends on mep_pkg; controlled by mep_ctrl through cmd_t
`default_nettype none

module mep_dp
    import mep_pkg::*;
#(
    parameter int ITER_BITS = 10
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cmd_t                        cmd,
    output status_t                          status,
    input  wire logic [PIX_W-1:0]            pixel_x,
    input  wire logic [PIX_W-1:0]            pixel_y,
    input  wire logic signed [WORD_W-1:0]    center_re,
    input  wire logic signed [WORD_W-1:0]    center_im,
    input  wire logic [WORD_W-1:0]           pixel_step,
    input  wire logic [SIZE_W-1:0]           image_width,
    input  wire logic [SIZE_W-1:0]           image_height,
    input  wire logic [ITER_BITS-1:0]        iteration_limit,
    output logic [ITER_BITS-1:0]             iterations,
    output logic [GRAY_W-1:0]                gray_level
);

    localparam int DW        = ITER_BITS + GRAY_W;
    localparam int MAP_SHIFT = 33 - FRAC_BITS;
    localparam logic [WIDE_W-1:0] ESC_LIM = WIDE_W'(1) << (2 * FRAC_BITS + 2);

    // pixel capture and mapping
    logic [PIX_W-1:0]         px_reg, py_reg;
    logic signed [OFF_W-1:0]  off_re, off_im;
    logic [MAG_W-1:0]         mag_re, mag_im;
    logic [PROD_W-1:0]        map_re_reg, map_im_reg;
    logic                     neg_re_reg, neg_im_reg;
    logic [PROD_W-1:0]        d_re, d_im;
    logic signed [SUM_W-1:0]  c_sum_re, c_sum_im;

    // iteration
    logic signed [WORD_W-1:0] cre_reg, cim_reg;
    logic signed [WORD_W-1:0] zre_reg, zim_reg;
    logic signed [WIDE_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg;
    logic [WIDE_W-1:0]        sq_sum;
    logic signed [WIDE_W-1:0] diff, nre, nim;
    logic [ITER_BITS-1:0]     count_reg;

    // gray divider
    logic [DW-1:0]            rem_reg, dsh_reg;
    logic [GRAY_W-1:0]        q_reg;
    logic [DCNT_W-1:0]        dcnt_reg;
    logic                     take;

    // output payload
    logic [ITER_BITS-1:0]     iterations_reg;
    logic [GRAY_W-1:0]        gray_reg;

    // 2*pixel - size, magnitude and sign
    always_comb
    begin
        off_re = $signed({2'b00, px_reg, 1'b0}) - $signed({2'b00, image_width});
        off_im = $signed({2'b00, py_reg, 1'b0}) - $signed({2'b00, image_height});
        mag_re = off_re[OFF_W-1] ? MAG_W'(-off_re) : off_re[MAG_W-1:0];
        mag_im = off_im[OFF_W-1] ? MAG_W'(-off_im) : off_im[MAG_W-1:0];
    end

    // offset brought to the fraction width, added to the center
    always_comb
    begin
        d_re     = map_re_reg >> MAP_SHIFT;
        d_im     = map_im_reg >> MAP_SHIFT;
        c_sum_re = neg_re_reg ? SUM_W'(center_re) - $signed({2'b00, d_re})
                              : SUM_W'(center_re) + $signed({2'b00, d_re});
        c_sum_im = neg_im_reg ? SUM_W'(center_im) - $signed({2'b00, d_im})
                              : SUM_W'(center_im) + $signed({2'b00, d_im});
    end

    // escape test on exact squares, next z with floor shifts
    always_comb
    begin
        sq_sum = $unsigned(p_rr_reg) + $unsigned(p_ii_reg);
        diff   = p_rr_reg - p_ii_reg;
        nre    = (diff >>> FRAC_BITS) + WIDE_W'(cre_reg);
        nim    = (p_ri_reg >>> (FRAC_BITS - 1)) + WIDE_W'(cim_reg);
    end

    // restoring division step, quotient known to fit the gray width
    assign take = (rem_reg >= dsh_reg) && (|iteration_limit);

    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (cmd.map_mul)
        begin
            map_re_reg <= {{WORD_W{1'b0}}, mag_re} * {{MAG_W{1'b0}}, pixel_step};
            map_im_reg <= {{WORD_W{1'b0}}, mag_im} * {{MAG_W{1'b0}}, pixel_step};
            neg_re_reg <= off_re[OFF_W-1];
            neg_im_reg <= off_im[OFF_W-1];
        end
        if (cmd.map_add)
        begin
            cre_reg   <= sat_word(WIDE_W'(c_sum_re));
            cim_reg   <= sat_word(WIDE_W'(c_sum_im));
            zre_reg   <= '0;
            zim_reg   <= '0;
            count_reg <= '0;
        end
        if (cmd.iter_mul)
        begin
            p_rr_reg <= zre_reg * zre_reg;
            p_ii_reg <= zim_reg * zim_reg;
            p_ri_reg <= zre_reg * zim_reg;
        end
        if (cmd.iter_upd)
        begin
            zre_reg   <= sat_word(nre);
            zim_reg   <= sat_word(nim);
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.div_start)
        begin
            rem_reg  <= {count_reg, {GRAY_W{1'b0}}} - {{GRAY_W{1'b0}}, count_reg};
            dsh_reg  <= {1'b0, iteration_limit, {(GRAY_W-1){1'b0}}};
            q_reg    <= '0;
            dcnt_reg <= DIV_FIRST;
        end
        if (cmd.div_step)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            q_reg    <= {q_reg[GRAY_W-2:0], take};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.out_load)
        begin
            iterations_reg <= count_reg;
            gray_reg       <= q_reg;
        end
    end

    assign status.count_done = (count_reg >= iteration_limit);
    assign status.escaped    = (sq_sum > ESC_LIM);
    assign status.div_last   = (dcnt_reg == '0);

    assign iterations = iterations_reg;
    assign gray_level = gray_reg;

    // an iteration is only committed below the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.iter_upd |-> (count_reg < iteration_limit))
        else $error("iteration past the limit");

endmodule

`default_nettype wire
